### rtl/nnis_pkg.sv
`timescale 1ns / 1ps
package nnis_pkg;
	localparam int MaxWidth = 128;
	localparam int MaxHeight = 128;
	localparam int ColW = $clog2(MaxWidth);
	localparam int RowW = $clog2(MaxHeight);
	localparam int AddrW = ColW + RowW;
	localparam int StoreDepth = MaxWidth * MaxHeight;
	localparam int PixW = 24;
	// Quotient bits developed per divider stage.
	localparam int QPerStage = 2;

	localparam logic [1:0] REG_SRC_WIDTH = 2'd0;
	localparam logic [1:0] REG_SRC_HEIGHT = 2'd1;
	localparam logic [1:0] REG_DST_WIDTH = 2'd2;
	localparam logic [1:0] REG_DST_HEIGHT = 2'd3;

	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_READ = 1'b1;
endpackage

### rtl/nnis_ram.sv
`timescale 1ns / 1ps
module nnis_ram #(
	parameter int Width = 24,
	parameter int Depth = 16384
) (
	input logic clk,
	input logic we,
	input logic [$clog2(Depth)-1:0] waddr,
	input logic [Width-1:0] wdata,
	input logic re,
	input logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0] rdata
);
	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

### rtl/nearest_neighbour_image_scaler.sv
`timescale 1ns / 1ps
// Channel   Dir  Handshake               tdata / tuser
// s_axis    in   s_axis_tvalid/tready    command, x, y, red, green, blue
// m_axis    out  m_axis_tvalid/tready    out_red, out_green, out_blue / range_error
// apb       in   psel, penable, pready   src_width, src_height, dst_width, dst_height
//
// One item is accepted per cycle when the pipeline advances. A read item passes eight register
// stages: range check and the two products, five radix-4 divider stages, the frame store read
// and the output register. A write item travels the same stages and updates the frame store
// where a read would sample it, so reads and writes act in order. The whole pipeline advances
// only when the output register is empty or being taken. Reset clears the valid bits and
// loads the configuration registers; the store is not cleared.
module nearest_neighbour_image_scaler
	import nnis_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic s_axis_tvalid,
	output logic s_axis_tready,
	// command[0], x[10:1], y[20:11], red[28:21], green[36:29], blue[44:37], zero pad
	input logic [47:0] s_axis_tdata,
	output logic m_axis_tvalid,
	input logic m_axis_tready,
	// out_red[7:0], out_green[15:8], out_blue[23:16]
	output logic [23:0] m_axis_tdata,
	// range_error[0]
	output logic m_axis_tuser,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [3:0] paddr,
	input logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);
	localparam int NStg = 10 / QPerStage;

	logic [7:0] src_w_q, src_h_q;
	logic [10:0] dst_w_q, dst_h_q;

	assign pready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_w_q <= 8'd128;
			src_h_q <= 8'd128;
			dst_w_q <= 11'd128;
			dst_h_q <= 11'd128;
		end else if (psel && penable && pwrite) begin
			case (paddr[3:2])
				REG_SRC_WIDTH: src_w_q <= pwdata[7:0];
				REG_SRC_HEIGHT: src_h_q <= pwdata[7:0];
				REG_DST_WIDTH: dst_w_q <= pwdata[10:0];
				REG_DST_HEIGHT: dst_h_q <= pwdata[10:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_SRC_WIDTH: prdata = {24'd0, src_w_q};
			REG_SRC_HEIGHT: prdata = {24'd0, src_h_q};
			REG_DST_WIDTH: prdata = {21'd0, dst_w_q};
			REG_DST_HEIGHT: prdata = {21'd0, dst_h_q};
			default: prdata = '0;
		endcase
	end

	logic [7:0] sw_eff, sh_eff;
	assign sw_eff = (src_w_q > 8'(MaxWidth)) ? 8'(MaxWidth) : src_w_q;
	assign sh_eff = (src_h_q > 8'(MaxHeight)) ? 8'(MaxHeight) : src_h_q;

	logic adv;
	assign adv = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = adv;

	logic in_acc;
	assign in_acc = s_axis_tvalid && adv;

	logic cmd;
	logic [9:0] in_x, in_y;
	logic [23:0] in_pix;
	assign cmd = s_axis_tdata[0];
	assign in_x = s_axis_tdata[10:1];
	assign in_y = s_axis_tdata[20:11];
	assign in_pix = {s_axis_tdata[28:21], s_axis_tdata[36:29], s_axis_tdata[44:37]};

	// Stage 1: write decode, read range check and product.
	logic wr_s1;
	logic [AddrW-1:0] waddr_s1;
	logic [23:0] wpix_s1;
	logic rv_s1, err_s1;
	logic [17:0] px_s1, py_s1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_s1 <= 1'b0;
			rv_s1 <= 1'b0;
		end else if (adv) begin
			wr_s1 <= in_acc && cmd == CMD_WRITE && {1'b0, in_x} < {3'd0, sw_eff}
				&& {1'b0, in_y} < {3'd0, sh_eff};
			rv_s1 <= in_acc && cmd == CMD_READ;
		end
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			waddr_s1 <= {in_y[RowW-1:0], in_x[ColW-1:0]};
			wpix_s1 <= in_pix;
			err_s1 <= {1'b0, in_x} >= dst_w_q || {1'b0, in_y} >= dst_h_q
				|| sw_eff == 8'd0 || sh_eff == 8'd0;
			px_s1 <= in_x * sw_eff;
			py_s1 <= in_y * sh_eff;
		end
	end

	// Divider pipeline: restoring radix-4, quotient of 10 bits (x < dst, so q < sw).
	logic vd [NStg+1];
	logic ed [NStg+1];
	logic [17:0] rxd [NStg+1];
	logic [17:0] ryd [NStg+1];
	logic [9:0] qxd [NStg+1];
	logic [9:0] qyd [NStg+1];
	logic wvd [NStg+1];
	logic [AddrW-1:0] wad [NStg+1];
	logic [PixW-1:0] wpd [NStg+1];

	assign vd[0] = rv_s1;
	assign ed[0] = err_s1;
	assign rxd[0] = px_s1;
	assign ryd[0] = py_s1;
	assign qxd[0] = '0;
	assign qyd[0] = '0;
	assign wvd[0] = wr_s1;
	assign wad[0] = waddr_s1;
	assign wpd[0] = wpix_s1;

	for (genvar s = 0; s < NStg; s++) begin : g_div
		logic [17:0] rx_n, ry_n;
		logic [9:0] qx_n, qy_n;
		always_comb begin
			logic [28:0] dx, dy;
			rx_n = rxd[s];
			ry_n = ryd[s];
			qx_n = qxd[s];
			qy_n = qyd[s];
			for (int b = 0; b < QPerStage; b++) begin
				dx = {11'd0, rx_n} - ({18'd0, dst_w_q} << (9 - s * QPerStage - b));
				dy = {11'd0, ry_n} - ({18'd0, dst_h_q} << (9 - s * QPerStage - b));
				qx_n = {qx_n[8:0], !dx[28]};
				qy_n = {qy_n[8:0], !dy[28]};
				if (!dx[28]) rx_n = dx[17:0];
				if (!dy[28]) ry_n = dy[17:0];
			end
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vd[s+1] <= 1'b0;
				wvd[s+1] <= 1'b0;
			end else if (adv) begin
				vd[s+1] <= vd[s];
				wvd[s+1] <= wvd[s];
			end
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				ed[s+1] <= ed[s];
				rxd[s+1] <= rx_n;
				ryd[s+1] <= ry_n;
				qxd[s+1] <= qx_n;
				qyd[s+1] <= qy_n;
				wad[s+1] <= wad[s];
				wpd[s+1] <= wpd[s];
			end
		end
	end

	// Frame store read, then output register.
	logic [AddrW-1:0] raddr;
	logic [PixW-1:0] rdata;
	assign raddr = {qyd[NStg][RowW-1:0], qxd[NStg][ColW-1:0]};

	logic rv_sr, err_sr;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rv_sr <= 1'b0;
		end else if (adv) begin
			rv_sr <= vd[NStg];
		end
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			err_sr <= ed[NStg];
		end
	end

	nnis_ram #(.Width(PixW), .Depth(StoreDepth)) u_store (
		.clk(clk),
		.we(wvd[NStg] && adv),
		.waddr(wad[NStg]),
		.wdata(wpd[NStg]),
		.re(adv),
		.raddr(raddr),
		.rdata(rdata)
	);

	logic [23:0] odata_q;
	logic oerr_q, ovalid_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (adv) begin
			ovalid_q <= rv_sr;
		end
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			oerr_q <= err_sr;
			odata_q <= err_sr ? 24'd0 : {rdata[7:0], rdata[15:8], rdata[23:16]};
		end
	end

	assign m_axis_tvalid = ovalid_q;
	assign m_axis_tdata = odata_q;
	assign m_axis_tuser = oerr_q;
endmodule
